>>> rtl/lcabl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcabl_pkg
// Shared types, codes and constants of the binary lifting ancestor unit.
// ----------------------------------------------------------------------------
package lcabl_pkg;

    // Field widths of the stream and configuration ports.
    localparam int ID_W    = 11;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Default sizes of the tree storage.
    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_LOG_LEVELS = 10;

    // Word index of the node count register.
    localparam logic [PADDR_W-3:0] REG_NODE_COUNT = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_CYCLE     = 2'd3
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [5:0] {
        DP_NOP, DP_LOAD, DP_CLR_STEP, DP_WR_PARENT, DP_BUILD_START,
        DP_CHK_RD, DP_CHK_EV, DP_W_START, DP_W_RD, DP_W_EV,
        DP_P_RD, DP_P_EV, DP_INC_I, DP_A_START, DP_A0_RD, DP_A0_WR,
        DP_SET_I1, DP_BUILD_OK, DP_AJ_RD1, DP_AJ_RD2, DP_AJ_WR, DP_LVL_INC,
        DP_Q_RD, DP_Q_EV, DP_L_RD, DP_L_EV, DP_T_RD, DP_T_EV,
        DP_D_RD, DP_D_EV, DP_F_RD, DP_F_EV, DP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_CHK_RD, S_CHK_EV, S_W_START, S_W_RD,
        S_W_EV, S_P_RD, S_P_EV, S_NEXT_I, S_A_INIT, S_A0_RD, S_A0_WR,
        S_AJ_CHECK, S_AJ_RD1, S_AJ_RD2, S_AJ_WR, S_AJ_NEXT, S_Q_EV, S_L_CHK,
        S_L_RD, S_L_EV, S_C_CHK, S_T_RD, S_T_EV, S_D_RD, S_D_EV, S_F_RD,
        S_F_EV, S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
        logic    use_x;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic a_ok;
        logic b_ok;
        logic tv;
        logic cnt_one;
        logic clr_last;
        logic i_last;
        logic par_bad;
        logic known;
        logic steps_zero;
        logic steps_one;
        logic steps_ge_cnt;
        logic lvl_done;
        logic diff_zero;
        logic xy_eq;
        logic anc_ne;
        logic lvl_zero;
        logic out_free;
    } dp_flags_t;

endpackage

>>> rtl/lcabl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcabl_dp
// Datapath: parent, depth, known and ancestor memories, walk registers and
// the output register.
// ----------------------------------------------------------------------------
module lcabl_dp #(
    parameter int MAX_NODES  = lcabl_pkg::DEF_MAX_NODES,
    parameter int LOG_LEVELS = lcabl_pkg::DEF_LOG_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lcabl_pkg::CMD_W-1:0]  in_cmd,
    input  logic [lcabl_pkg::ID_W-1:0]   in_a,
    input  logic [lcabl_pkg::ID_W-1:0]   in_b,
    input  logic [lcabl_pkg::CFG_W-1:0]  node_count,
    input  logic                         cfg_clear,
    input  lcabl_pkg::dp_cmd_t           cmd,
    output lcabl_pkg::dp_flags_t         flags,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lcabl_pkg::ID_W-1:0]   out_ancestor,
    output logic [lcabl_pkg::ST_W-1:0]   out_status
);
    import lcabl_pkg::*;

    localparam int NW        = $clog2(MAX_NODES + 1);
    localparam int LW        = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int AW        = LW + NW;
    localparam int ANC_DEPTH = LOG_LEVELS << NW;
    localparam logic [LW-1:0] TOP = LW'(LOG_LEVELS - 1);

    // Memories.
    logic [NW-1:0] par_mem   [0:MAX_NODES];
    logic [NW-1:0] dep_mem   [0:MAX_NODES];
    logic          known_mem [0:MAX_NODES];
    logic [NW-1:0] anc_mem   [0:ANC_DEPTH-1];

    // Registers.
    logic [CMD_W-1:0] cmd_reg;
    logic [ID_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]    i_reg, i_next, cur_reg, cur_next, steps_reg, steps_next;
    logic [NW-1:0]    d_reg, d_next, x_reg, x_next, y_reg, y_next;
    logic [NW-1:0]    diff_reg, diff_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    logic             tv_reg, tv_next, out_valid_reg, out_valid_next;
    logic [ID_W-1:0]  out_anc_reg, out_anc_next;
    logic [ST_W-1:0]  out_st_reg, out_st_next;
    logic [NW-1:0]    par_rd_reg, depa_rd_reg, depb_rd_reg, anca_rd_reg, ancb_rd_reg;
    logic             known_rd_reg;

    // Memory port controls.
    logic          par_we, dep_we, kn_we, kn_wdata, anc_we;
    logic [NW-1:0] par_waddr, par_wdata, par_raddr, dep_waddr, dep_wdata;
    logic [NW-1:0] depa_raddr, depb_raddr, kn_waddr, kn_raddr, anc_wdata;
    logic [AW-1:0] anc_waddr, anca_raddr, ancb_raddr;

    logic [NW-1:0] cnt, a_n, b_n, top_span;
    logic [NW-1:0] diff_after;
    logic [LW-1:0] lift_lvl;

    // Clamp the configured node count to the supported range.
    always_comb
    begin
        if (int'(node_count) == 0)
            cnt = NW'(1);
        else if (int'(node_count) > MAX_NODES)
            cnt = NW'(MAX_NODES);
        else
            cnt = NW'(node_count);
    end

    assign a_n      = NW'(a_reg);
    assign b_n      = NW'(b_reg);
    assign top_span = NW'(1) << (LOG_LEVELS - 1);

    // Lift step: the top column for long distances, else the lowest set bit.
    always_comb
    begin
        lift_lvl   = '0;
        diff_after = diff_reg;
        if ((diff_reg >> LOG_LEVELS) != '0)
        begin
            lift_lvl   = TOP;
            diff_after = diff_reg - top_span;
        end
        else
        begin
            for (int j = NW - 1; j >= 0; j--)
            begin
                if (j < LOG_LEVELS && diff_reg[j])
                    lift_lvl = LW'(j);
            end
            diff_after = diff_reg & ~(NW'(1) << lift_lvl);
        end
    end

    // Memory addresses and writes.
    always_comb
    begin
        par_we = 1'b0; par_waddr = i_reg; par_wdata = NW'(1); par_raddr = i_reg;
        dep_we = 1'b0; dep_waddr = cur_reg; dep_wdata = d_reg;
        depa_raddr = cur_reg; depb_raddr = b_n;
        kn_we = 1'b0; kn_waddr = cur_reg; kn_wdata = 1'b1; kn_raddr = cur_reg;
        anc_we = 1'b0; anc_waddr = {lvl_reg, i_reg}; anc_wdata = par_rd_reg;
        anca_raddr = {lvl_reg, x_reg}; ancb_raddr = {lvl_reg, y_reg};
        case (cmd.op)
            DP_CLR_STEP:
                par_we = 1'b1;
            DP_WR_PARENT:
            begin
                par_we    = (int'(a_reg) != 1);
                par_waddr = a_n;
                par_wdata = b_n;
            end
            DP_BUILD_START:
            begin
                dep_we = 1'b1; dep_waddr = NW'(1); dep_wdata = '0;
                kn_we  = 1'b1; kn_waddr  = NW'(1); kn_wdata  = 1'b1;
            end
            DP_CHK_EV:
            begin
                kn_we = 1'b1; kn_waddr = i_reg; kn_wdata = 1'b0;
            end
            DP_W_RD:
                par_raddr = cur_reg;
            DP_P_RD:
            begin
                par_raddr = cur_reg;
                dep_we    = 1'b1;
                kn_we     = 1'b1;
            end
            DP_A0_WR:
            begin
                anc_we    = 1'b1;
                anc_waddr = {LW'(0), i_reg};
                anc_wdata = par_rd_reg;
            end
            DP_AJ_RD1:
                anca_raddr = {lvl_reg, i_reg};
            DP_AJ_RD2:
                anca_raddr = {lvl_reg, anca_rd_reg};
            DP_AJ_WR:
            begin
                anc_we    = 1'b1;
                anc_waddr = {lvl_reg + LW'(1), i_reg};
                anc_wdata = anca_rd_reg;
            end
            DP_Q_RD:
            begin
                depa_raddr = a_n;
                depb_raddr = b_n;
            end
            DP_L_RD:
                anca_raddr = {lift_lvl, x_reg};
            DP_T_RD:
            begin
                anca_raddr = {TOP, x_reg};
                ancb_raddr = {TOP, y_reg};
            end
            DP_F_RD:
                anca_raddr = {LW'(0), x_reg};
            default:
                ;
        endcase
    end

    // Memory write and registered read ports.
    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        if (dep_we)
            dep_mem[dep_waddr] <= dep_wdata;
        if (kn_we)
            known_mem[kn_waddr] <= kn_wdata;
        if (anc_we)
            anc_mem[anc_waddr] <= anc_wdata;
        par_rd_reg   <= par_mem[par_raddr];
        depa_rd_reg  <= dep_mem[depa_raddr];
        depb_rd_reg  <= dep_mem[depb_raddr];
        known_rd_reg <= known_mem[kn_raddr];
        anca_rd_reg  <= anc_mem[anca_raddr];
        ancb_rd_reg  <= anc_mem[ancb_raddr];
    end

    // Next values of the working registers.
    always_comb
    begin
        a_next = a_reg; b_next = b_reg;
        i_next = i_reg; cur_next = cur_reg; steps_next = steps_reg; d_next = d_reg;
        x_next = x_reg; y_next = y_reg; diff_next = diff_reg; lvl_next = lvl_reg;
        tv_next = tv_reg; out_valid_next = out_valid_reg;
        out_anc_next = out_anc_reg; out_st_next = out_st_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        case (cmd.op)
            DP_LOAD:
            begin
                a_next = in_a;
                b_next = in_b;
            end
            DP_CLR_STEP:
                i_next = i_reg + NW'(1);
            DP_WR_PARENT:
                tv_next = 1'b0;
            DP_BUILD_START:
            begin
                tv_next = 1'b0;
                i_next  = NW'(2);
            end
            DP_CHK_EV:
                i_next = (i_reg == cnt) ? NW'(2) : i_reg + NW'(1);
            DP_W_START:
            begin
                cur_next   = i_reg;
                steps_next = '0;
            end
            DP_W_EV:
            begin
                if (known_rd_reg)
                begin
                    d_next   = depa_rd_reg + steps_reg;
                    cur_next = i_reg;
                end
                else
                begin
                    cur_next   = par_rd_reg;
                    steps_next = steps_reg + NW'(1);
                end
            end
            DP_P_EV:
            begin
                cur_next   = par_rd_reg;
                d_next     = d_reg - NW'(1);
                steps_next = steps_reg - NW'(1);
            end
            DP_INC_I, DP_A0_WR, DP_AJ_WR:
                i_next = i_reg + NW'(1);
            DP_A_START:
            begin
                i_next   = NW'(1);
                lvl_next = '0;
            end
            DP_SET_I1:
                i_next = NW'(1);
            DP_BUILD_OK:
                tv_next = 1'b1;
            DP_LVL_INC:
                lvl_next = lvl_reg + LW'(1);
            DP_Q_RD:
            begin
                x_next = a_n;
                y_next = b_n;
            end
            DP_Q_EV:
            begin
                if (depa_rd_reg < depb_rd_reg)
                begin
                    x_next    = y_reg;
                    y_next    = x_reg;
                    diff_next = depb_rd_reg - depa_rd_reg;
                end
                else
                    diff_next = depa_rd_reg - depb_rd_reg;
            end
            DP_L_RD:
                diff_next = diff_after;
            DP_L_EV, DP_F_EV:
                x_next = anca_rd_reg;
            DP_T_EV:
            begin
                lvl_next = TOP;
                if (anca_rd_reg != ancb_rd_reg)
                begin
                    x_next = anca_rd_reg;
                    y_next = ancb_rd_reg;
                end
            end
            DP_D_EV:
            begin
                if (lvl_reg != '0)
                    lvl_next = lvl_reg - LW'(1);
                if (anca_rd_reg != ancb_rd_reg)
                begin
                    x_next = anca_rd_reg;
                    y_next = ancb_rd_reg;
                end
            end
            DP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_anc_next   = cmd.use_x ? ID_W'(x_reg) : '0;
                out_st_next    = cmd.status;
            end
            default:
                ;
        endcase
        if (cfg_clear)
            tv_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            tv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            tv_reg        <= tv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
            cmd_reg <= in_cmd;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        d_reg       <= d_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        diff_reg    <= diff_next;
        lvl_reg     <= lvl_next;
        out_anc_reg <= out_anc_next;
        out_st_reg  <= out_st_next;
    end

    // Status toward the controller.
    always_comb
    begin
        flags.cmd          = cmd_reg;
        flags.a_ok         = (a_reg != '0) && (int'(a_reg) <= int'(cnt));
        flags.b_ok         = (b_reg != '0) && (int'(b_reg) <= int'(cnt));
        flags.tv           = tv_reg;
        flags.cnt_one      = (cnt == NW'(1));
        flags.clr_last     = (int'(i_reg) == MAX_NODES);
        flags.i_last       = (i_reg == cnt);
        flags.par_bad      = (par_rd_reg == '0) || (par_rd_reg > cnt);
        flags.known        = known_rd_reg;
        flags.steps_zero   = (steps_reg == '0);
        flags.steps_one    = (steps_reg == NW'(1));
        flags.steps_ge_cnt = (steps_reg >= cnt);
        flags.lvl_done     = (int'(lvl_reg) + 2 > LOG_LEVELS);
        flags.diff_zero    = (diff_reg == '0);
        flags.xy_eq        = (x_reg == y_reg);
        flags.anc_ne       = (anca_rd_reg != ancb_rd_reg);
        flags.lvl_zero     = (lvl_reg == '0);
        flags.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_ancestor = out_anc_reg;
    assign out_status   = out_st_reg;

endmodule

>>> rtl/lcabl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcabl_ctrl
// Controller: sequences clearing, parent writes, table builds and queries.
// ----------------------------------------------------------------------------
module lcabl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output lcabl_pkg::dp_cmd_t   cmd,
    input  lcabl_pkg::dp_flags_t flags
);
    import lcabl_pkg::*;

    ctrl_state_t state_reg, state_next;
    status_t     st_reg, st_next;
    logic        use_x_reg, use_x_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            st_reg    <= ST_OK;
            use_x_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            use_x_reg <= use_x_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        use_x_next = use_x_reg;
        in_ready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.status = st_reg;
        cmd.use_x  = use_x_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = DP_CLR_STEP;
                if (flags.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                use_x_next = 1'b0;
                st_next    = ST_OK;
                state_next = S_DONE;
                case (flags.cmd)
                    CMD_WRITE:
                    begin
                        if (!(flags.a_ok && flags.b_ok))
                            st_next = ST_RANGE;
                        else
                            cmd.op = DP_WR_PARENT;
                    end
                    CMD_BUILD:
                    begin
                        cmd.op     = DP_BUILD_START;
                        state_next = flags.cnt_one ? S_A_INIT : S_CHK_RD;
                    end
                    CMD_QUERY:
                    begin
                        if (!(flags.a_ok && flags.b_ok))
                            st_next = ST_RANGE;
                        else if (!flags.tv)
                            st_next = ST_NOT_BUILT;
                        else
                        begin
                            cmd.op     = DP_Q_RD;
                            state_next = S_Q_EV;
                        end
                    end
                    default:
                        ;
                endcase
            end
            S_CHK_RD:
            begin
                cmd.op     = DP_CHK_RD;
                state_next = S_CHK_EV;
            end
            S_CHK_EV:
            begin
                if (flags.par_bad)
                begin
                    st_next    = ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_CHK_EV;
                    state_next = flags.i_last ? S_W_START : S_CHK_RD;
                end
            end
            S_W_START:
            begin
                cmd.op     = DP_W_START;
                state_next = S_W_RD;
            end
            S_W_RD:
            begin
                cmd.op     = DP_W_RD;
                state_next = S_W_EV;
            end
            S_W_EV:
            begin
                if (flags.known)
                begin
                    cmd.op     = DP_W_EV;
                    state_next = flags.steps_zero ? S_NEXT_I : S_P_RD;
                end
                else if (flags.steps_ge_cnt)
                begin
                    st_next    = ST_CYCLE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_W_EV;
                    state_next = S_W_RD;
                end
            end
            S_P_RD:
            begin
                cmd.op     = DP_P_RD;
                state_next = S_P_EV;
            end
            S_P_EV:
            begin
                cmd.op     = DP_P_EV;
                state_next = flags.steps_one ? S_NEXT_I : S_P_RD;
            end
            S_NEXT_I:
            begin
                if (flags.i_last)
                begin
                    cmd.op     = DP_A_START;
                    state_next = S_A0_RD;
                end
                else
                begin
                    cmd.op     = DP_INC_I;
                    state_next = S_W_START;
                end
            end
            S_A_INIT:
            begin
                cmd.op     = DP_A_START;
                state_next = S_A0_RD;
            end
            S_A0_RD:
            begin
                cmd.op     = DP_A0_RD;
                state_next = S_A0_WR;
            end
            S_A0_WR:
            begin
                cmd.op     = DP_A0_WR;
                state_next = flags.i_last ? S_AJ_CHECK : S_A0_RD;
            end
            S_AJ_CHECK:
            begin
                if (flags.lvl_done)
                begin
                    cmd.op     = DP_BUILD_OK;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_SET_I1;
                    state_next = S_AJ_RD1;
                end
            end
            S_AJ_RD1:
            begin
                cmd.op     = DP_AJ_RD1;
                state_next = S_AJ_RD2;
            end
            S_AJ_RD2:
            begin
                cmd.op     = DP_AJ_RD2;
                state_next = S_AJ_WR;
            end
            S_AJ_WR:
            begin
                cmd.op     = DP_AJ_WR;
                state_next = flags.i_last ? S_AJ_NEXT : S_AJ_RD1;
            end
            S_AJ_NEXT:
            begin
                cmd.op     = DP_LVL_INC;
                state_next = S_AJ_CHECK;
            end
            S_Q_EV:
            begin
                cmd.op     = DP_Q_EV;
                state_next = S_L_CHK;
            end
            S_L_CHK:
                state_next = flags.diff_zero ? S_C_CHK : S_L_RD;
            S_L_RD:
            begin
                cmd.op     = DP_L_RD;
                state_next = S_L_EV;
            end
            S_L_EV:
            begin
                cmd.op     = DP_L_EV;
                state_next = S_L_CHK;
            end
            S_C_CHK:
            begin
                if (flags.xy_eq)
                begin
                    use_x_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_T_RD;
            end
            S_T_RD:
            begin
                cmd.op     = DP_T_RD;
                state_next = S_T_EV;
            end
            S_T_EV:
            begin
                cmd.op     = DP_T_EV;
                state_next = flags.anc_ne ? S_T_RD : S_D_RD;
            end
            S_D_RD:
            begin
                cmd.op     = DP_D_RD;
                state_next = S_D_EV;
            end
            S_D_EV:
            begin
                cmd.op     = DP_D_EV;
                state_next = flags.lvl_zero ? S_F_RD : S_D_RD;
            end
            S_F_RD:
            begin
                cmd.op     = DP_F_RD;
                state_next = S_F_EV;
            end
            S_F_EV:
            begin
                cmd.op     = DP_F_EV;
                use_x_next = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_INIT;
        endcase
    end

`ifndef NO_ASSERTIONS
    // An accepted transaction is always decoded in the following cycle.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_DISPATCH))
        else $error("accepted transaction not dispatched");

    // A result is only pushed when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_EMIT) |-> flags.out_free)
        else $error("result pushed into a full output register");

    // A cycle is only reported from the upward walk.
    a_cycle_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_next == S_DONE && st_next == ST_CYCLE && state_reg != S_DONE)
        |-> (state_reg == S_W_EV))
        else $error("cycle status from an unexpected state");
`endif

endmodule

>>> rtl/lca_binary_lifting_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_binary_lifting_unit
// Lowest common ancestor unit using a binary lifting ancestor table.
// ----------------------------------------------------------------------------
// Usage: each s_axis transaction carries a command (write parent, build,
// query) and two node ids; each produces exactly one m_axis transaction with
// the ancestor (zero unless a query succeeds) and a status code.
// The node count register sits at APB address 0; writing it invalidates the
// built tables. Write it only while the unit is idle.
// A parent write, an unused command or a rejected item is decoded in the
// dispatch state and its result is emitted from the done state. A query
// lifts the deeper node to the other's depth, climbs by the top ancestor
// level while the top ancestors differ, descends the levels and then takes
// the parent. A build checks every parent, walks each node up to a node of
// known depth, then fills ancestor level 0 and each higher level in turn.
// Items are processed one at a time; a new item is taken once the previous
// one has its result in the output register, even if that result is stalled.
// After reset the parent memory is cleared to the root entry by entry,
// during which no item is accepted; APB writes work throughout.
// A stalled receiver holds the result; the next result then waits inside the
// unit and no further item is accepted until the output register frees up.
// ----------------------------------------------------------------------------
module lca_binary_lifting_unit #(
    parameter int MAX_NODES  = lcabl_pkg::DEF_MAX_NODES,
    parameter int LOG_LEVELS = lcabl_pkg::DEF_LOG_LEVELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // cmd[1:0], node_a[12:2], node_b[23:13]
    input  logic [23:0]                    s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // ancestor[10:0], status[12:11], zero fill[15:13]
    output logic [15:0]                    m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcabl_pkg::PADDR_W-1:0]  paddr,
    input  logic [lcabl_pkg::PDATA_W-1:0]  pwdata,
    output logic [lcabl_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import lcabl_pkg::*;

    logic [CFG_W-1:0] node_count_reg, node_count_next;
    logic             cfg_wr, reg_hit;
    logic             ready;
    dp_cmd_t          cmd;
    dp_flags_t        flags;
    logic [ID_W-1:0]  out_anc;
    logic [ST_W-1:0]  out_st;

    // APB register decode.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_NODE_COUNT);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? PDATA_W'(node_count_reg) : '0;

    always_comb
    begin
        node_count_next = cfg_wr ? pwdata[CFG_W-1:0] : node_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= CFG_W'(1);
        else
            node_count_reg <= node_count_next;
    end

    lcabl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (ready),
        .cmd      (cmd),
        .flags    (flags)
    );

    lcabl_dp #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_cmd       (s_axis_tdata[1:0]),
        .in_a         (s_axis_tdata[12:2]),
        .in_b         (s_axis_tdata[23:13]),
        .node_count   (node_count_reg),
        .cfg_clear    (cfg_wr),
        .cmd          (cmd),
        .flags        (flags),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_ancestor (out_anc),
        .out_status   (out_st)
    );

    assign s_axis_tready = ready;
    assign m_axis_tdata  = {3'b000, out_st, out_anc};

endmodule

>>> dv/tb_lca_binary_lifting_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lca_binary_lifting_unit
// Self-checking bench for the binary lifting common ancestor unit.
// ----------------------------------------------------------------------------
// Parent writes, table builds and ancestor queries are streamed into the unit
// over several node count settings. A behavioral tree model in the bench
// predicts the ancestor and status of every accepted transaction, and a
// monitor compares each returned transaction with the oldest prediction.
// Both stream sides idle at random; the receiver once holds off for a long
// stretch so that the unit stalls its input.
// ----------------------------------------------------------------------------
module tb_lca_binary_lifting_unit;
    import lcabl_pkg::*;

    localparam int NODE_LIM = 1024;
    localparam int LEVELS   = 10;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  node_a;
        logic [ID_W-1:0]  node_b;
    } tree_op_t;

    typedef struct {
        logic [ID_W-1:0] ancestor;
        status_t         status;
    } lca_answer_t;

    logic                 clk;
    logic                 rst_n;
    logic [23:0]          s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shadow tree state.
    int       node_cfg;
    bit       built;
    int       parent_of [0:NODE_LIM];
    int       depth_of  [0:NODE_LIM];
    int       jump      [0:LEVELS-1][0:NODE_LIM];
    bit       depth_set [0:NODE_LIM];

    tree_op_t    op_queue[$];
    lca_answer_t answer_queue[$];
    int          errors;
    int          answers_seen;
    int          ops_made;
    int          in_gap;
    int          out_gap;
    int          hold_left;
    bit          hold_done;
    bit          calm;
    bit          in_taken;

    lca_binary_lifting_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock and timeout watchdog.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[lca_binary_lifting_unit] ERROR");
        $finish;
    end

    function automatic int live_count();
        if (node_cfg == 0)
            return 1;
        if (node_cfg > NODE_LIM)
            return NODE_LIM;
        return node_cfg;
    endfunction

    function automatic bit id_valid(int id, int n);
        return id >= 1 && id <= n;
    endfunction

    // Parent range check, depth walk with memoization, then the power-of-two ancestor fill.
    function automatic status_t build_tables(int n);
        int cur;
        int steps;
        int d;
        built = 1'b0;
        for (int i = 2; i <= n; i++)
            if (parent_of[i] < 1 || parent_of[i] > n)
                return ST_RANGE;
        for (int i = 0; i <= NODE_LIM; i++)
            depth_set[i] = 1'b0;
        depth_set[1] = 1'b1;
        depth_of[1] = 0;
        for (int i = 2; i <= n; i++)
        begin
            cur = i;
            steps = 0;
            while (!depth_set[cur])
            begin
                if (steps >= n)
                    return ST_CYCLE;
                cur = parent_of[cur];
                steps++;
            end
            d = depth_of[cur] + steps;
            cur = i;
            while (!depth_set[cur])
            begin
                depth_of[cur] = d;
                depth_set[cur] = 1'b1;
                d--;
                cur = parent_of[cur];
            end
        end
        for (int i = 1; i <= n; i++)
            jump[0][i] = parent_of[i];
        for (int j = 1; j < LEVELS; j++)
            for (int i = 1; i <= n; i++)
                jump[j][i] = jump[j-1][jump[j-1][i]];
        built = 1'b1;
        return ST_OK;
    endfunction

    // Lift deeper node to the other's level, climb by top level, descend, take parent.
    function automatic int common_ancestor(int x, int y);
        int t;
        int diff;
        int top_span;
        top_span = 1 << (LEVELS - 1);
        if (depth_of[x] < depth_of[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        diff = depth_of[x] - depth_of[y];
        while (diff >= 2 * top_span)
        begin
            x = jump[LEVELS-1][x];
            diff -= top_span;
        end
        for (int j = 0; j < LEVELS; j++)
            if ((diff >> j) & 1)
                x = jump[j][x];
        if (x == y)
            return x;
        while (jump[LEVELS-1][x] != jump[LEVELS-1][y])
        begin
            x = jump[LEVELS-1][x];
            y = jump[LEVELS-1][y];
        end
        for (int j = LEVELS - 1; j >= 0; j--)
            if (jump[j][x] != jump[j][y])
            begin
                x = jump[j][x];
                y = jump[j][y];
            end
        return jump[0][x];
    endfunction

    function automatic lca_answer_t predict_answer(tree_op_t op);
        lca_answer_t r;
        int n;
        n = live_count();
        r.ancestor = '0;
        r.status = ST_OK;
        case (op.cmd)
            CMD_WRITE:
                if (!id_valid(int'(op.node_a), n) || !id_valid(int'(op.node_b), n))
                    r.status = ST_RANGE;
                else
                begin
                    if (op.node_a != 1)
                        parent_of[op.node_a] = int'(op.node_b);
                    built = 1'b0;
                end
            CMD_BUILD:
                r.status = build_tables(n);
            CMD_QUERY:
                if (!id_valid(int'(op.node_a), n) || !id_valid(int'(op.node_b), n))
                    r.status = ST_RANGE;
                else if (!built)
                    r.status = ST_NOT_BUILT;
                else
                    r.ancestor = ID_W'(common_ancestor(int'(op.node_a),
                                                       int'(op.node_b)));
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Stream sampling: predict on input acceptance, check on output acceptance.
    always @(posedge clk)
    begin
        tree_op_t    op;
        lca_answer_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            op.cmd    = s_axis_tdata[1:0];
            op.node_a = s_axis_tdata[12:2];
            op.node_b = s_axis_tdata[23:13];
            answer_queue.insert(answer_queue.size(), predict_answer(op));
            in_taken = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            answers_seen++;
            if (answer_queue.size() == 0)
                report("result transaction with nothing expected");
            else
            begin
                want = answer_queue.pop_front();
                if (m_axis_tdata[10:0] != want.ancestor)
                    report($sformatf("ancestor %0d, expected %0d",
                        m_axis_tdata[10:0], want.ancestor));
                if (m_axis_tdata[12:11] != want.status)
                    report($sformatf("status %0d, expected %0d",
                        m_axis_tdata[12:11], want.status));
            end
        end
    end

    // Input driver: fed from the pending queue, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (op_queue.size() > 0)
            begin
                tree_op_t op;
                op = op_queue.pop_front();
                s_axis_tdata  <= {op.node_b, op.node_a, op.cmd};
                s_axis_tvalid <= 1'b1;
                in_gap = pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, and one long hold-off to back the unit up.
    always @(negedge clk)
    begin
        if (!hold_done && answers_seen >= 200)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    task automatic push_op(logic [CMD_W-1:0] cmd, int a, int b);
        tree_op_t op;
        op.cmd    = cmd;
        op.node_a = ID_W'(a);
        op.node_b = ID_W'(b);
        op_queue.insert(op_queue.size(), op);
        ops_made++;
    endtask

    task automatic wait_idle();
        wait (op_queue.size() == 0 && answer_queue.size() == 0 && !s_axis_tvalid);
        repeat (20) @(negedge clk);
    endtask

    task automatic apb_write(int value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_NODE_COUNT, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_cfg = value & 32'h7FF;
        built = 1'b0;
    endtask

    function automatic int any_id();
        return $urandom_range(0, 2047);
    endfunction

    // One tree with random shape, a build and queries, plus noise.
    task automatic tree_phase(int n, int chain_pct, int n_queries);
        int x;
        for (int i = 2; i <= n; i++)
        begin
            if ($urandom_range(0, 99) < chain_pct)
                push_op(CMD_WRITE, i, i - 1);
            else
                push_op(CMD_WRITE, i, $urandom_range(1, i - 1));
            if ($urandom_range(0, 99) < 4)
                push_op(CMD_W'($urandom_range(0, 3)), any_id(), any_id());
        end
        if ($urandom_range(0, 3) == 0)
            push_op(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
        if (n > 3 && $urandom_range(0, 4) == 0)
        begin
            // Repoint a node somewhere random: may close a loop.
            x = $urandom_range(2, n);
            push_op(CMD_WRITE, x, $urandom_range(2, n));
        end
        push_op(CMD_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047));
        for (int q = 0; q < n_queries; q++)
        begin
            if ($urandom_range(0, 99) < 8)
                push_op(CMD_QUERY, any_id(), any_id());
            else
                push_op(CMD_QUERY, $urandom_range(1, n), $urandom_range(1, n));
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        int n;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        answers_seen = 0;
        ops_made = 0;
        in_gap = 0;
        out_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        calm = 1'b0;
        in_taken = 1'b0;
        node_cfg = 1;
        built = 1'b0;
        for (int i = 0; i <= NODE_LIM; i++)
            parent_of[i] = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single-node tree, range checks, unused command.
        push_op(CMD_QUERY, 1, 1);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_QUERY, 1, 1);
        push_op(CMD_WRITE, 1, 1);
        push_op(CMD_SPARE, 2047, 2047);
        push_op(CMD_QUERY, 0, 1);
        push_op(CMD_QUERY, 1, 2047);
        push_op(CMD_WRITE, 2, 1);
        wait_idle();

        // Directed: largest count, far ids, and a parent left stale later.
        apb_write(2047);
        push_op(CMD_WRITE, 1024, 1);
        push_op(CMD_WRITE, 3, 1024);
        push_op(CMD_WRITE, 10, 999);
        push_op(CMD_WRITE, 1025, 1);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_QUERY, 1024, 3);
        push_op(CMD_QUERY, 3, 500);
        wait_idle();
        apb_write(0);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_QUERY, 1, 1);
        wait_idle();

        // Directed: stale parent, then a two-node loop, then the repair.
        apb_write(12);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_WRITE, 10, 1);
        push_op(CMD_WRITE, 2, 3);
        push_op(CMD_WRITE, 3, 2);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_QUERY, 2, 3);
        push_op(CMD_WRITE, 3, 1);
        push_op(CMD_BUILD, 0, 0);
        push_op(CMD_QUERY, 2, 12);
        wait_idle();

        // Random phases over many counts, one deep chain among them.
        apb_write(300);
        tree_phase(300, 90, 30);
        wait_idle();
        while (ops_made < 700)
        begin
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(2, 40);
            apb_write(n);
            tree_phase(n, $urandom_range(0, 80), $urandom_range(5, 30));
            wait_idle();
        end
        calm = 1'b0;

        // A big table with mostly default parents.
        apb_write(1024);
        for (int i = 0; i < 20; i++)
            push_op(CMD_WRITE, $urandom_range(2, 1024), $urandom_range(1, 1024));
        push_op(CMD_BUILD, 0, 0);
        for (int i = 0; i < 15; i++)
            push_op(CMD_QUERY, $urandom_range(1, 1024), $urandom_range(1, 1024));
        wait_idle();
        repeat (100) @(negedge clk);

        if (errors == 0)
            $display("[lca_binary_lifting_unit] OK");
        else
            $display("[lca_binary_lifting_unit] ERROR");
        $finish;
    end

endmodule
